// File: hdl/swh_pkg.sv
// Shared types and constants for the spike word histogram unit.
// No dependencies; every other file takes names from here, by scope or by import.
package swh_pkg;

  localparam int MAX_WORD_BITS_DEF = 10;
  localparam int COUNT_WIDTH_DEF   = 32;

  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;
  localparam int SAMPLE_W   = 16;
  localparam int BIN_LEN_W  = 16;
  localparam int WORD_LEN_W = 4;
  localparam int OUT_WORD_W = 10;
  localparam int BIN_IDX_W  = 10;
  localparam int OUT_CNT_W  = 32;

  localparam logic [1:0] REG_UP_THR   = 2'd0;
  localparam logic [1:0] REG_DOWN_THR = 2'd1;
  localparam logic [1:0] REG_BIN_LEN  = 2'd2;
  localparam logic [1:0] REG_WORD_LEN = 2'd3;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  localparam logic signed [SAMPLE_W-1:0] UP_THR_RST   = 16'sd0;
  localparam logic signed [SAMPLE_W-1:0] DOWN_THR_RST = -16'sd100;
  localparam logic [BIN_LEN_W-1:0]       BIN_LEN_RST  = 16'd20;
  localparam logic [WORD_LEN_W-1:0]      WORD_LEN_RST = 4'd8;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] up_thr;
    logic signed [SAMPLE_W-1:0] down_thr;
    logic [BIN_LEN_W-1:0]       bin_len;
    logic [WORD_LEN_W-1:0]      word_len;
  } cfg_t;

  typedef struct packed {
    logic rd;
    logic close;
  } item_ctl_t;

endpackage

// File: hdl/swh_cfg.sv
// APB-style register file: thresholds, bin length and word length.
// Depends on swh_pkg for register indexes, reset values and cfg_t.
module swh_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [swh_pkg::ADDR_W-1:0] paddr,
  input  logic [swh_pkg::DATA_W-1:0] pwdata,
  output logic [swh_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output swh_pkg::cfg_t              cfg
);

  swh_pkg::cfg_t cfg_r;
  logic          wr_en;
  logic [1:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.up_thr   <= swh_pkg::UP_THR_RST;
      cfg_r.down_thr <= swh_pkg::DOWN_THR_RST;
      cfg_r.bin_len  <= swh_pkg::BIN_LEN_RST;
      cfg_r.word_len <= swh_pkg::WORD_LEN_RST;
    end else if (wr_en) begin
      case (reg_idx)
        swh_pkg::REG_UP_THR:   cfg_r.up_thr   <= pwdata[15:0];
        swh_pkg::REG_DOWN_THR: cfg_r.down_thr <= pwdata[15:0];
        swh_pkg::REG_BIN_LEN:  cfg_r.bin_len  <= pwdata[15:0];
        swh_pkg::REG_WORD_LEN: cfg_r.word_len <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      swh_pkg::REG_UP_THR:   prdata = {{16{cfg_r.up_thr[15]}}, cfg_r.up_thr};
      swh_pkg::REG_DOWN_THR: prdata = {{16{cfg_r.down_thr[15]}}, cfg_r.down_thr};
      swh_pkg::REG_BIN_LEN:  prdata = {16'd0, cfg_r.bin_len};
      swh_pkg::REG_WORD_LEN: prdata = {28'd0, cfg_r.word_len};
      default:               prdata = '0;
    endcase
  end

endmodule

// File: hdl/swh_front.sv
// Front stage: spike detector, bin counter, word shift and sample total.
// Produces the histogram read address per beat. Depends on swh_pkg.
module swh_front #(
  parameter int MAX_WORD_BITS = swh_pkg::MAX_WORD_BITS_DEF,
  parameter int COUNT_WIDTH   = swh_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  swh_pkg::cfg_t                       cfg,
  input  logic                                accept,
  input  logic                                in_command,
  input  logic signed [swh_pkg::SAMPLE_W-1:0] in_sample,
  input  logic [swh_pkg::BIN_IDX_W-1:0]       in_bin_index,
  output logic [MAX_WORD_BITS-1:0]            rd_addr,
  output swh_pkg::item_ctl_t                  item,
  output logic [swh_pkg::OUT_WORD_W-1:0]      item_word,
  output logic [COUNT_WIDTH-1:0]              item_total
);

  localparam int MW = MAX_WORD_BITS;
  localparam int OW = swh_pkg::OUT_WORD_W;

  logic                           spk_r, spk_nxt;
  logic                           seen_r, seen_nxt;
  logic [swh_pkg::BIN_LEN_W-1:0]  cnt_r, cnt_nxt, cnt_inc;
  logic [MW-1:0]                  ws_r, ws_nxt, ws_upd;
  logic [COUNT_WIDTH-1:0]         total_r, total_nxt;
  logic [MW-1:0]                  mask, word_cur, word_new;
  logic [4:0]                     len;
  logic                           is_sample, close, seen_base;

  assign is_sample = (in_command == swh_pkg::CMD_SAMPLE);
  assign cnt_inc   = cnt_r + 16'd1;
  assign close     = is_sample & (cnt_inc == cfg.bin_len);
  assign ws_upd    = MW'({ws_r, seen_r});
  assign len       = (5'(cfg.word_len) > 5'(MW)) ? 5'(MW) : 5'(cfg.word_len);

  always_comb begin
    for (int i = 0; i < MW; i++) begin
      mask[i] = (5'(i) < len);
    end
  end

  assign word_cur = ws_r & mask;
  assign word_new = ws_upd & mask;

  always_comb begin
    spk_nxt   = spk_r;
    seen_nxt  = seen_r;
    cnt_nxt   = cnt_r;
    ws_nxt    = ws_r;
    total_nxt = total_r;
    seen_base = close ? 1'b0 : seen_r;
    if (is_sample) begin
      total_nxt = (total_r == '1) ? total_r : total_r + 1'b1;
      cnt_nxt   = close ? '0 : cnt_inc;
      ws_nxt    = close ? ws_upd : ws_r;
      seen_nxt  = seen_base;
      if (in_sample > cfg.up_thr) begin
        seen_nxt = seen_base | ~spk_r;
        spk_nxt  = 1'b1;
      end else if (in_sample < cfg.down_thr) begin
        spk_nxt = 1'b0;
      end
    end
  end

  assign rd_addr    = is_sample ? word_new : MW'(in_bin_index);
  assign item.rd    = ~is_sample;
  assign item.close = close;
  assign item_word  = OW'(close ? word_new : word_cur);
  assign item_total = total_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spk_r   <= 1'b0;
      seen_r  <= 1'b0;
      cnt_r   <= '0;
      ws_r    <= '0;
      total_r <= '0;
    end else if (accept) begin
      spk_r   <= spk_nxt;
      seen_r  <= seen_nxt;
      cnt_r   <= cnt_nxt;
      ws_r    <= ws_nxt;
      total_r <= total_nxt;
    end
  end

endmodule

// File: hdl/swh_hist.sv
// Histogram memory with clearing pass, read-modify-write stage with
// write forwarding, and the output register. Depends on swh_pkg.
module swh_hist #(
  parameter int MAX_WORD_BITS = swh_pkg::MAX_WORD_BITS_DEF,
  parameter int COUNT_WIDTH   = swh_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  output logic                           accept,
  input  logic [MAX_WORD_BITS-1:0]       rd_addr,
  input  swh_pkg::item_ctl_t             item,
  input  logic [swh_pkg::OUT_WORD_W-1:0] item_word,
  input  logic [COUNT_WIDTH-1:0]         item_total,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_word_valid,
  output logic [swh_pkg::OUT_WORD_W-1:0] out_word,
  output logic [swh_pkg::OUT_CNT_W-1:0]  out_bin_count,
  output logic [swh_pkg::OUT_CNT_W-1:0]  out_sample_total
);

  localparam int MW    = MAX_WORD_BITS;
  localparam int DEPTH = 1 << MW;
  localparam int CW    = swh_pkg::OUT_CNT_W;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  logic [COUNT_WIDTH-1:0] mem [DEPTH];
  logic [COUNT_WIDTH-1:0] rdata_r, cur, inc;
  logic [MW-1:0]          clr_r;

  logic                   s1_v_r;
  swh_pkg::item_ctl_t     s1_ctl_r;
  logic [MW-1:0]          s1_addr_r;
  logic [swh_pkg::OUT_WORD_W-1:0] s1_word_r;
  logic [COUNT_WIDTH-1:0] s1_total_r;
  logic                   s1_go;

  logic                   fwd_v_r;
  logic [MW-1:0]          fwd_addr_r;
  logic [COUNT_WIDTH-1:0] fwd_data_r;

  logic                   we;
  logic [MW-1:0]          wa;
  logic [COUNT_WIDTH-1:0] wd;
  logic                   upd;

  assign s1_go    = s1_v_r & ~(out_valid & out_stall);
  assign in_stall = (state_r != ST_RUN) | (s1_v_r & ~s1_go);
  assign accept   = in_valid & ~in_stall;

  assign cur = (fwd_v_r && fwd_addr_r == s1_addr_r) ? fwd_data_r : rdata_r;
  assign inc = (cur == '1) ? cur : cur + 1'b1;
  assign upd = s1_go & s1_ctl_r.close;

  always_comb begin
    if (state_r == ST_CLEAR) begin
      we = 1'b1;
      wa = clr_r;
      wd = '0;
    end else begin
      we = upd;
      wa = s1_addr_r;
      wd = inc;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_r == MW'(DEPTH - 1)) state_nxt = ST_RUN;
      ST_RUN:   state_nxt = ST_RUN;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (accept) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      fwd_v_r <= 1'b0;
      s1_v_r  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (upd) begin
        fwd_v_r <= 1'b1;
      end
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end
      if (s1_go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      fwd_addr_r <= s1_addr_r;
      fwd_data_r <= inc;
    end
    if (accept) begin
      s1_ctl_r   <= item;
      s1_addr_r  <= rd_addr;
      s1_word_r  <= item_word;
      s1_total_r <= item_total;
    end
    if (s1_go) begin
      out_word_valid   <= s1_ctl_r.close;
      out_word         <= s1_word_r;
      out_bin_count    <= s1_ctl_r.rd ? CW'(cur) : '0;
      out_sample_total <= CW'(s1_total_r);
    end
  end

endmodule

// File: hdl/spike_word_histogram_unit.sv
// Top level of the spike word histogram unit.
// Instantiates swh_cfg, swh_front and swh_hist; depends on swh_pkg.
//
// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_stall   in_command, in_sample, in_bin_index
// out      output     out_valid/out_stall out_word_valid, out_word,
//                                         out_bin_count, out_sample_total
// cfg      input      psel/penable/pready paddr, pwdata, prdata
//
// One beat per cycle sustained while out_stall and the clearing pass allow;
// the histogram is read when the input beat is accepted, then incremented and
// written back with forwarding as the output register loads the result.
// After reset a clearing pass zeroes all 2^MAX_WORD_BITS histogram entries,
// one entry per cycle; in_stall stays high meanwhile.
// out_stall holds the output register; one further beat is taken into the
// read-modify-write stage before in_stall rises.
module spike_word_histogram_unit #(
  parameter int MAX_WORD_BITS = swh_pkg::MAX_WORD_BITS_DEF,
  parameter int COUNT_WIDTH   = swh_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_command,
  input  logic signed [swh_pkg::SAMPLE_W-1:0] in_sample,
  input  logic [swh_pkg::BIN_IDX_W-1:0]       in_bin_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_word_valid,
  output logic [swh_pkg::OUT_WORD_W-1:0]      out_word,
  output logic [swh_pkg::OUT_CNT_W-1:0]       out_bin_count,
  output logic [swh_pkg::OUT_CNT_W-1:0]       out_sample_total,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [swh_pkg::ADDR_W-1:0]          paddr,
  input  logic [swh_pkg::DATA_W-1:0]          pwdata,
  output logic [swh_pkg::DATA_W-1:0]          prdata,
  output logic                                pready
);

  swh_pkg::cfg_t                  cfg;
  swh_pkg::item_ctl_t             item;
  logic                           accept;
  logic [MAX_WORD_BITS-1:0]       rd_addr;
  logic [swh_pkg::OUT_WORD_W-1:0] item_word;
  logic [COUNT_WIDTH-1:0]         item_total;

  swh_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  swh_front #(
    .MAX_WORD_BITS (MAX_WORD_BITS),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .accept       (accept),
    .in_command   (in_command),
    .in_sample    (in_sample),
    .in_bin_index (in_bin_index),
    .rd_addr      (rd_addr),
    .item         (item),
    .item_word    (item_word),
    .item_total   (item_total)
  );

  swh_hist #(
    .MAX_WORD_BITS (MAX_WORD_BITS),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_hist (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .accept           (accept),
    .rd_addr          (rd_addr),
    .item             (item),
    .item_word        (item_word),
    .item_total       (item_total),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_word_valid   (out_word_valid),
    .out_word         (out_word),
    .out_bin_count    (out_bin_count),
    .out_sample_total (out_sample_total)
  );

endmodule

// File: hdl/swh_checker.sv
// Port-level checks for spike_word_histogram_unit, attached by bind.
// Depends on swh_pkg for port widths.
module swh_assertions (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           out_word_valid,
  input logic [swh_pkg::OUT_CNT_W-1:0]  out_bin_count,
  input logic [swh_pkg::OUT_CNT_W-1:0]  out_sample_total
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  a_clear_pass: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input taken during histogram clearing pass");

  a_sample_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word_valid |-> out_bin_count == '0 && out_sample_total != '0)
    else $error("bin closing beat with nonzero bin_count or zero total");

endmodule

bind spike_word_histogram_unit swh_assertions u_swh_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_word_valid   (out_word_valid),
  .out_bin_count    (out_bin_count),
  .out_sample_total (out_sample_total)
);

// File: tb/swh_checker.sv
// Checker for the spike word histogram unit: watches the sample, result and
// register ports, predicts each result beat and compares it field by field.
// Depends on swh_pkg for widths, register codes, commands and reset values.
module swh_checker
  import swh_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       in_command,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic [BIN_IDX_W-1:0]       in_bin_index,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic                       out_word_valid,
  input  logic [OUT_WORD_W-1:0]      out_word,
  input  logic [OUT_CNT_W-1:0]       out_bin_count,
  input  logic [OUT_CNT_W-1:0]       out_sample_total,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [DATA_W-1:0]          pwdata,
  output int                         err_count,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORD_BITS  = MAX_WORD_BITS_DEF;
  localparam int HIST_DEPTH = 1 << WORD_BITS;
  localparam logic [OUT_CNT_W-1:0] COUNT_SAT = '1;

  typedef struct packed {
    logic                  word_valid;
    logic [OUT_WORD_W-1:0] word;
    logic [OUT_CNT_W-1:0]  bin_count;
    logic [OUT_CNT_W-1:0]  sample_total;
  } spike_result_t;

  cfg_t                 model_cfg;
  logic                 spiking;
  logic                 spike_seen;
  logic [BIN_LEN_W-1:0] bin_cnt;
  logic [WORD_BITS-1:0] word_reg;
  logic [OUT_CNT_W-1:0] word_hist [HIST_DEPTH];
  logic [OUT_CNT_W-1:0] total_count;
  spike_result_t        expected_words [$];

  function automatic logic [OUT_WORD_W-1:0] masked_word();
    int          len;
    int unsigned mask;
    len  = (model_cfg.word_len > WORD_BITS) ? WORD_BITS : int'(model_cfg.word_len);
    mask = (1 << len) - 1;
    return OUT_WORD_W'(word_reg & mask);
  endfunction

  function automatic logic [OUT_CNT_W-1:0] sat_inc(input logic [OUT_CNT_W-1:0] c);
    return (c == COUNT_SAT) ? c : c + 1'b1;
  endfunction

  task automatic step_spike_model(input logic cmd, input logic signed [SAMPLE_W-1:0] smp,
                                  input logic [BIN_IDX_W-1:0] idx,
                                  output spike_result_t res);
    logic [OUT_WORD_W-1:0] w;
    res = '0;
    if (cmd == CMD_READ) begin
      res.bin_count = word_hist[idx];
    end else begin
      total_count = sat_inc(total_count);
      bin_cnt     = bin_cnt + 1'b1;
      if (bin_cnt == model_cfg.bin_len) begin
        word_reg       = {word_reg[WORD_BITS-2:0], spike_seen};
        w              = masked_word();
        word_hist[w]   = sat_inc(word_hist[w]);
        bin_cnt        = '0;
        spike_seen     = 1'b0;
        res.word_valid = 1'b1;
      end
      if (smp > $signed(model_cfg.up_thr)) begin
        if (!spiking) spike_seen = 1'b1;
        spiking = 1'b1;
      end else if (smp < $signed(model_cfg.down_thr)) begin
        spiking = 1'b0;
      end
    end
    res.word         = masked_word();
    res.sample_total = total_count;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  always @(posedge clk) begin : monitor
    spike_result_t exp_r;
    if (!rst_n) begin
      model_cfg.up_thr   = UP_THR_RST;
      model_cfg.down_thr = DOWN_THR_RST;
      model_cfg.bin_len  = BIN_LEN_RST;
      model_cfg.word_len = WORD_LEN_RST;
      spiking            = 1'b0;
      spike_seen         = 1'b0;
      bin_cnt            = '0;
      word_reg           = '0;
      total_count        = '0;
      for (int i = 0; i < HIST_DEPTH; i++) word_hist[i] = '0;
      expected_words.delete();
      err_count = 0;
      pending  <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_UP_THR:   model_cfg.up_thr   = pwdata[SAMPLE_W-1:0];
          REG_DOWN_THR: model_cfg.down_thr = pwdata[SAMPLE_W-1:0];
          REG_BIN_LEN:  model_cfg.bin_len  = pwdata[BIN_LEN_W-1:0];
          REG_WORD_LEN: model_cfg.word_len = pwdata[WORD_LEN_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          report_mismatch("beat without expectation", 32'(out_word), '0);
        end else begin
          exp_r = expected_words.pop_front();
          if (out_word_valid !== exp_r.word_valid)
            report_mismatch("word_valid", 32'(out_word_valid), 32'(exp_r.word_valid));
          if (out_word !== exp_r.word)
            report_mismatch("word", 32'(out_word), 32'(exp_r.word));
          if (out_bin_count !== exp_r.bin_count)
            report_mismatch("bin_count", out_bin_count, exp_r.bin_count);
          if (out_sample_total !== exp_r.sample_total)
            report_mismatch("sample_total", out_sample_total, exp_r.sample_total);
        end
      end
      if (in_valid && !in_stall) begin
        step_spike_model(in_command, in_sample, in_bin_index, exp_r);
        expected_words.push_back(exp_r);
      end
      pending <= expected_words.size();
    end
  end

endmodule

// File: tb/tb_top.sv
// Top of the spike word histogram testbench: clock, reset, sample and
// register stimulus, random idling on both channels, watchdog and verdict.
// Depends on swh_pkg, spike_word_histogram_unit and swh_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import swh_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PHASES  = 16;
  localparam int PHASE_ITEMS    = 100;
  localparam int TAIL_ITEMS     = 40;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic                       in_command;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic [BIN_IDX_W-1:0]       in_bin_index;
  logic                       out_valid;
  logic                       out_stall;
  logic                       out_word_valid;
  logic [OUT_WORD_W-1:0]      out_word;
  logic [OUT_CNT_W-1:0]       out_bin_count;
  logic [OUT_CNT_W-1:0]       out_sample_total;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [ADDR_W-1:0]          paddr;
  logic [DATA_W-1:0]          pwdata;
  logic [DATA_W-1:0]          prdata;
  logic                       pready;

  int err_count;
  int pending;
  int cur_up;
  int cur_down;
  int cur_bin;
  int cur_wl;
  int bin_pos;
  int idle_cycles = 0;
  bit in_burst;
  bit out_burst;

  spike_word_histogram_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_sample        (in_sample),
    .in_bin_index     (in_bin_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_word_valid   (out_word_valid),
    .out_word         (out_word),
    .out_bin_count    (out_bin_count),
    .out_sample_total (out_sample_total),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  swh_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_sample        (in_sample),
    .in_bin_index     (in_bin_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_word_valid   (out_word_valid),
    .out_word         (out_word),
    .out_bin_count    (out_bin_count),
    .out_sample_total (out_sample_total),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .err_count        (err_count),
    .pending          (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic write_reg(input logic [1:0] sel, input logic [15:0] value,
                           input logic [15:0] pad);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= {pad, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_config(input int up, input int down, input int bin, input int wl);
    logic [31:0] junk;
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    junk = $urandom;
    write_reg(REG_UP_THR, 16'(up), junk[31:16]);
    write_reg(REG_DOWN_THR, 16'(down), junk[15:0]);
    junk = $urandom;
    write_reg(REG_BIN_LEN, 16'(bin), junk[31:16]);
    write_reg(REG_WORD_LEN, {junk[15:4], 4'(wl)}, 16'($urandom));
    cur_up   = up;
    cur_down = down;
    cur_bin  = bin & 16'hFFFF;
    cur_wl   = wl;
  endtask

  task automatic send_beat(input logic cmd, input logic signed [SAMPLE_W-1:0] smp,
                           input logic [BIN_IDX_W-1:0] idx);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_sample    <= smp;
    in_bin_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (cmd == CMD_SAMPLE) begin
      bin_pos = (bin_pos + 1) & 16'hFFFF;
      if (bin_pos == cur_bin) bin_pos = 0;
    end
    @(negedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = cur_up + int'($urandom_range(1, 60));
      3, 4, 5: v = cur_down - int'($urandom_range(1, 60));
      6, 7:    v = (($urandom_range(0, 1) == 1) ? cur_up : cur_down)
                   + int'($urandom_range(0, 2)) - 1;
      default: v = int'($urandom_range(0, 65535)) - 32768;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  task automatic send_random_item();
    logic [BIN_IDX_W-1:0] idx;
    int                   len;
    idx = 10'($urandom);
    if ($urandom_range(0, 99) < 15) begin
      len = (cur_wl > 10) ? 10 : cur_wl;
      if ($urandom_range(0, 1) == 1) idx = idx & 10'((1 << len) - 1);
      send_beat(CMD_READ, pick_sample(), idx);
    end else begin
      send_beat(CMD_SAMPLE, pick_sample(), idx);
    end
  endtask

  task automatic pick_random_config(output int up, output int down, output int bin,
                                    output int wl);
    case ($urandom_range(0, 5))
      0:       up = -32768;
      1:       up = 32767;
      default: up = int'($urandom_range(0, 4000)) - 2000;
    endcase
    case ($urandom_range(0, 5))
      0:       down = -32768;
      1:       down = 32767;
      2:       down = int'($urandom_range(0, 65535)) - 32768;
      default: down = up - int'($urandom_range(0, 400));
    endcase
    if (down < -32768) down = -32768;
    case ($urandom_range(0, 7))
      0:       bin = 1;
      1:       bin = 20;
      2:       bin = $urandom_range(7, 40);
      default: bin = $urandom_range(1, 6);
    endcase
    wl = $urandom_range(0, 15);
  endtask

  initial begin
    int hold;
    int beats;
    out_stall = 1'b0;
    beats     = 0;
    @(negedge clk);
    forever begin
      if (beats % 64 == 0) out_burst = ($urandom_range(0, 3) == 0);
      hold = out_burst ? 0 : $urandom_range(0, 19);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      beats++;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int up, down, bin, wl;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_command   = CMD_SAMPLE;
    in_sample    = '0;
    in_bin_index = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_burst     = 1'b0;
    cur_up       = 0;
    cur_down     = -100;
    cur_bin      = 20;
    cur_wl       = 8;
    bin_pos      = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_beat(CMD_READ, 16'sh7FFF, 10'd0);
    send_beat(CMD_SAMPLE, 16'sd1, 10'h3FF);
    send_beat(CMD_READ, -16'sd32768, 10'h3FF);

    apply_config(100, -100, 2, 10);
    send_beat(CMD_SAMPLE, 16'sd32767, 10'd0);
    send_beat(CMD_SAMPLE, -16'sd32768, 10'h3FF);
    send_beat(CMD_SAMPLE, 16'sd100, 10'd0);
    send_beat(CMD_SAMPLE, 16'sd101, 10'd0);
    send_beat(CMD_SAMPLE, 16'sd101, 10'd0);
    send_beat(CMD_SAMPLE, -16'sd100, 10'd0);
    send_beat(CMD_SAMPLE, -16'sd101, 10'd0);
    send_beat(CMD_SAMPLE, 16'sd0, 10'd0);
    send_beat(CMD_SAMPLE, 16'sd32767, 10'd0);
    send_beat(CMD_SAMPLE, -16'sd32768, 10'd0);
    send_beat(CMD_READ, 16'sh5555, 10'd0);
    send_beat(CMD_READ, -16'sd1, 10'd1);
    send_beat(CMD_READ, 16'sh2AAA, 10'd2);
    send_beat(CMD_READ, 16'sd0, 10'h3FF);
    send_beat(CMD_READ, 16'sd0, 10'h200);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       begin up = -32768; down = -32768; bin = 1; wl = 1;  end
        1:       begin up = 32767;  down = 32767;  bin = 2; wl = 10; end
        2:       begin up = 500;    down = -500;   bin = 3; wl = 0;  end
        3:       begin up = 0;      down = -100;   bin = 1; wl = 15; end
        4:       begin up = -200;   down = 200;    bin = 4; wl = 11; end
        default: pick_random_config(up, down, bin, wl);
      endcase
      if (bin <= bin_pos) bin = bin_pos + 1;
      apply_config(up, down, bin, wl);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 25 == 0) in_burst = ($urandom_range(0, 3) == 0);
        send_random_item();
      end
    end

    // long bins last: zero length and a length below the running count never close
    for (int t = 0; t < 3; t++) begin
      pick_random_config(up, down, bin, wl);
      case (t)
        0:       begin bin = 65535; wl = 10; end
        1:       bin = 0;
        default: bin = 2;
      endcase
      apply_config(up, down, bin, wl);
      for (int k = 0; k < TAIL_ITEMS; k++) begin
        if (k % 20 == 0) in_burst = ($urandom_range(0, 3) == 0);
        send_random_item();
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
